>>> hdl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// combinational property sampled every clock outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// next-cycle implication outside reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that is also checked across reset
`define ASSERT_NEXT_ANY(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/u2kb_pkg.sv
// types, constants and code page table for the utf-8 to keybcs2 transcoder
`default_nettype none

package u2kb_pkg;

   localparam int TblSize = 48;

   localparam logic [7:0] SubstChar = 8'h5F;

   typedef struct packed {
      logic [7:0] code;
      logic       substituted;
   } rsp_word_type;

   localparam logic [15:0] MAP_CP [TblSize] = '{
      16'h010C, 16'h00FC, 16'h00E9, 16'h010F, 16'h00E4, 16'h010E, 16'h0164, 16'h010D,
      16'h011B, 16'h011A, 16'h0139, 16'h00CD, 16'h013E, 16'h013A, 16'h00C4, 16'h00C1,
      16'h00C9, 16'h017E, 16'h017D, 16'h00F4, 16'h00F6, 16'h00D3, 16'h016F, 16'h00DA,
      16'h00FD, 16'h00D6, 16'h00DC, 16'h0160, 16'h013D, 16'h00DD, 16'h0158, 16'h0165,
      16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h0148, 16'h0147, 16'h016E, 16'h00D4,
      16'h0161, 16'h0159, 16'h0155, 16'h0154, 16'h00BC, 16'h00A7, 16'h00AB, 16'h00BB
   };

   localparam logic [7:0] MAP_CODE [TblSize] = '{
      8'h80, 8'h75, 8'h82, 8'h83, 8'h61, 8'h85, 8'h86, 8'h87,
      8'h88, 8'h89, 8'h4C, 8'h8B, 8'h6C, 8'h6C, 8'h41, 8'h8F,
      8'h90, 8'h91, 8'h92, 8'h6F, 8'h6F, 8'h95, 8'h96, 8'h97,
      8'h98, 8'h4F, 8'h55, 8'h9B, 8'h4C, 8'h9D, 8'h9E, 8'h9F,
      8'hA0, 8'hA1, 8'hA2, 8'hA3, 8'hA4, 8'hA5, 8'hA6, 8'h4F,
      8'hA8, 8'hA9, 8'h72, 8'h52, 8'hAC, 8'hAD, 8'h3C, 8'h3E
   };

   // map a completed code point to its output word
   function automatic rsp_word_type map_code_point(input logic [20:0] cp);
      rsp_word_type w;
      logic         hit;
      w.code        = SubstChar;
      w.substituted = 1'b1;
      hit           = 1'b0;
      if (cp <= 21'h000080) begin
         w.code        = cp[7:0];
         w.substituted = 1'b0;
      end else begin
         for (int i = 0; i < TblSize; i++) begin
            if (!hit && (cp == {5'd0, MAP_CP[i]})) begin
               hit           = 1'b1;
               w.code        = MAP_CODE[i];
               w.substituted = 1'b0;
            end
         end
      end
      return w;
   endfunction

endpackage

`default_nettype wire

>>> hdl/utf8_to_keybcs2_transcoder_core.sv
// utf-8 to keybcs2 transcoder: decoder, table lookup and result buffering
// a word that completes a character is registered into the output register, or into skid under rsp stall
// throughput: one byte per cycle while req_stall is low, one decode and lookup per byte
// two-entry result buffer (output register plus skid); req_stall is high while skid is full
// reset: synchronous active high, clears the pending sequence and both result slots
`default_nettype none

module utf8_to_keybcs2_transcoder_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_in_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_char,
   output logic            rsp_substituted
);

   logic [20:0] accum_ff, accum_in;
   logic [1:0]  left_ff, left_in;
   logic        out_valid_ff, out_valid_in;
   logic        skid_valid_ff, skid_valid_in;
   u2kb_pkg::rsp_word_type out_ff, out_in;
   u2kb_pkg::rsp_word_type skid_ff, skid_in;
   u2kb_pkg::rsp_word_type new_word;
   logic [20:0] shifted;
   logic        accept;
   logic        emit;
   logic        out_free;

   assign accept  = req_valid && !req_stall;
   assign shifted = {accum_ff[14:0], req_in_byte[5:0]};

   // byte classification and sequence state
   always_comb begin
      accum_in      = accum_ff;
      left_in       = left_ff;
      emit          = 1'b0;
      new_word.code = req_in_byte;
      new_word.substituted = 1'b0;
      if (!req_in_byte[7]) begin
         emit = 1'b1;
      end else if (req_in_byte[7:6] == 2'b10) begin
         if (left_ff != 2'd0) begin
            accum_in = shifted;
            left_in  = left_ff - 2'd1;
            if (left_ff == 2'd1) begin
               emit     = 1'b1;
               new_word = u2kb_pkg::map_code_point(shifted);
            end
         end
      end else if (req_in_byte[7:5] == 3'b110) begin
         accum_in = {16'd0, req_in_byte[4:0]};
         left_in  = 2'd1;
      end else if (req_in_byte[7:4] == 4'b1110) begin
         accum_in = {17'd0, req_in_byte[3:0]};
         left_in  = 2'd2;
      end else if (req_in_byte[7:3] == 5'b11110) begin
         accum_in = {18'd0, req_in_byte[2:0]};
         left_in  = 2'd3;
      end else begin
         accum_in = '0;
         left_in  = 2'd0;
      end
   end

   // output register with skid slot
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_free      = !out_valid_ff || !rsp_stall;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = accept && emit;
            skid_in       = new_word;
         end else begin
            out_valid_in  = accept && emit;
            out_in        = new_word;
         end
      end else if (accept && emit) begin
         skid_valid_in = 1'b1;
         skid_in       = new_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff      <= '0;
         left_ff       <= 2'd0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            accum_ff <= accum_in;
            left_ff  <= left_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign req_stall       = skid_valid_ff;
   assign rsp_valid       = out_valid_ff;
   assign rsp_out_char    = out_ff.code;
   assign rsp_substituted = out_ff.substituted;

endmodule

`default_nettype wire

>>> hdl/u2kb_checker.sv
// port-level checks for the utf-8 to keybcs2 transcoder
`default_nettype none
`include "assert_macros.svh"

module u2kb_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic [7:0] req_in_byte,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_out_char,
   input wire logic       rsp_substituted
);

   logic [7:0] last_byte_ff;
   logic       ascii_take;
   logic       ascii_echo;
   logic       subst_ok;
   logic       rsp_wait;
   logic [8:0] rsp_word;

   always_ff @(posedge clock) begin
      last_byte_ff <= req_in_byte;
   end

   assign ascii_take = req_valid && !req_stall && !req_in_byte[7] && !rsp_valid;
   assign ascii_echo = rsp_valid && rsp_out_char == last_byte_ff && !rsp_substituted;
   assign subst_ok   = !(rsp_valid && rsp_substituted) || rsp_out_char == u2kb_pkg::SubstChar;
   assign rsp_wait   = rsp_valid && rsp_stall;
   assign rsp_word   = {rsp_out_char, rsp_substituted};

   `ASSERT_NEXT_ANY(a_reset_empty, clock, reset, !rsp_valid, "rsp valid right after reset")
   `ASSERT_NEXT(a_ascii_direct, clock, reset, ascii_take, ascii_echo, "ascii word not passed through")
   `ASSERT_ALWAYS(a_subst_char, clock, reset, subst_ok, "substituted word is not underscore")
   `ASSERT_ALWAYS(a_stall_full, clock, reset, !req_stall || rsp_valid, "input stalled, output empty")
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_valid && $stable(rsp_word), "stalled word changed")

endmodule

bind utf8_to_keybcs2_transcoder_core u2kb_checker u_u2kb_checker (.*);

`default_nettype wire

>>> bench/tb.sv
// self-checking bench for the utf-8 to keybcs2 transcoder: byte stimulus, char predictor, checker
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WatchdogLimit = 5000;
   localparam int DirectedLen   = 26;

   localparam logic [7:0] Directed [DirectedLen] = '{
      8'h00, 8'h7F,
      8'hC4, 8'h8C,
      8'h80,
      8'hC4, 8'h41, 8'h8C,
      8'hE2, 8'hC3, 8'hA9,
      8'hF0, 8'h9F, 8'h98, 8'h80,
      8'hC0, 8'h80,
      8'hC2, 8'h80,
      8'hE0, 8'hFF, 8'h80,
      8'hF7, 8'hBF, 8'hBF, 8'hBF
   };

   class keybcs2_tracker;
      logic [20:0]            cp_accum;
      logic [2:0]             conts_left;
      u2kb_pkg::rsp_word_type pending_chars[$];
      int                     errors;

      function new();
         cp_accum   = '0;
         conts_left = '0;
         errors     = 0;
      endfunction

      task report(input string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         errors++;
      endtask

      function void enqueue(input u2kb_pkg::rsp_word_type w);
         pending_chars = {pending_chars, w};
      endfunction

      function u2kb_pkg::rsp_word_type lookup(input logic [20:0] cp);
         u2kb_pkg::rsp_word_type w;
         w.code        = cp[7:0];
         w.substituted = 1'b0;
         if (cp > 21'h000080) begin
            case (cp)
               21'h0010C: w.code = 8'h80;
               21'h000FC: w.code = 8'h75;
               21'h000E9: w.code = 8'h82;
               21'h0010F: w.code = 8'h83;
               21'h000E4: w.code = 8'h61;
               21'h0010E: w.code = 8'h85;
               21'h00164: w.code = 8'h86;
               21'h0010D: w.code = 8'h87;
               21'h0011B: w.code = 8'h88;
               21'h0011A: w.code = 8'h89;
               21'h00139: w.code = 8'h4C;
               21'h000CD: w.code = 8'h8B;
               21'h0013E: w.code = 8'h6C;
               21'h0013A: w.code = 8'h6C;
               21'h000C4: w.code = 8'h41;
               21'h000C1: w.code = 8'h8F;
               21'h000C9: w.code = 8'h90;
               21'h0017E: w.code = 8'h91;
               21'h0017D: w.code = 8'h92;
               21'h000F4: w.code = 8'h6F;
               21'h000F6: w.code = 8'h6F;
               21'h000D3: w.code = 8'h95;
               21'h0016F: w.code = 8'h96;
               21'h000DA: w.code = 8'h97;
               21'h000FD: w.code = 8'h98;
               21'h000D6: w.code = 8'h4F;
               21'h000DC: w.code = 8'h55;
               21'h00160: w.code = 8'h9B;
               21'h0013D: w.code = 8'h4C;
               21'h000DD: w.code = 8'h9D;
               21'h00158: w.code = 8'h9E;
               21'h00165: w.code = 8'h9F;
               21'h000E1: w.code = 8'hA0;
               21'h000ED: w.code = 8'hA1;
               21'h000F3: w.code = 8'hA2;
               21'h000FA: w.code = 8'hA3;
               21'h00148: w.code = 8'hA4;
               21'h00147: w.code = 8'hA5;
               21'h0016E: w.code = 8'hA6;
               21'h000D4: w.code = 8'h4F;
               21'h00161: w.code = 8'hA8;
               21'h00159: w.code = 8'hA9;
               21'h00155: w.code = 8'h72;
               21'h00154: w.code = 8'h52;
               21'h000BC: w.code = 8'hAC;
               21'h000A7: w.code = 8'hAD;
               21'h000AB: w.code = 8'h3C;
               21'h000BB: w.code = 8'h3E;
               default: begin
                  w.code        = u2kb_pkg::SubstChar;
                  w.substituted = 1'b1;
               end
            endcase
         end
         return w;
      endfunction

      function void take_byte(input logic [7:0] b);
         if (!b[7]) begin
            enqueue(lookup({13'd0, b}));
         end else if (b[7:6] == 2'b10) begin
            if (conts_left != 3'd0) begin
               cp_accum   = {cp_accum[14:0], b[5:0]};
               conts_left = conts_left - 3'd1;
               if (conts_left == 3'd0) enqueue(lookup(cp_accum));
            end
         end else if (b[7:5] == 3'b110) begin
            cp_accum   = {16'd0, b[4:0]};
            conts_left = 3'd1;
         end else if (b[7:4] == 4'b1110) begin
            cp_accum   = {17'd0, b[3:0]};
            conts_left = 3'd2;
         end else if (b[7:3] == 5'b11110) begin
            cp_accum   = {18'd0, b[2:0]};
            conts_left = 3'd3;
         end else begin
            cp_accum   = '0;
            conts_left = '0;
         end
      endfunction

      task match_char(input logic [7:0] code, input logic substituted);
         u2kb_pkg::rsp_word_type w;
         if (pending_chars.size() == 0) begin
            report($sformatf("unexpected word code=%02h subst=%0b", code, substituted));
         end else begin
            w = pending_chars.pop_front();
            if (code !== w.code)
               report($sformatf("out_char %02h, predicted %02h", code, w.code));
            if (substituted !== w.substituted)
               report($sformatf("substituted %0b, predicted %0b", substituted, w.substituted));
         end
      endtask

      function int outstanding();
         return pending_chars.size();
      endfunction

      task close_out();
         if (pending_chars.size() != 0)
            report($sformatf("%0d predicted words never arrived", pending_chars.size()));
      endtask
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic [7:0] req_in_byte = 8'h00;
   logic       rsp_stall = 1'b0;
   logic       req_stall;
   logic       rsp_valid;
   logic [7:0] rsp_out_char;
   logic       rsp_substituted;

   keybcs2_tracker track;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int bytes_sent    = 0;
   int quiet_cycles  = 0;

   utf8_to_keybcs2_transcoder_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_char    (rsp_out_char),
      .rsp_substituted (rsp_substituted)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) track.take_byte(req_in_byte);
         if (rsp_valid && !rsp_stall) track.match_char(rsp_out_char, rsp_substituted);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WatchdogLimit) begin
            $display("watchdog: no word moved for %0d cycles", WatchdogLimit);
            $display("Verification failed");
            $finish;
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   // sends the first keep bytes of the nbytes-long encoding of cp
   task automatic send_code_point(input logic [20:0] cp, input int nbytes, input int keep);
      logic [7:0] lead;
      int         i;
      case (nbytes)
         2:       lead = {3'b110, cp[10:6]};
         3:       lead = {4'b1110, cp[15:12]};
         default: lead = {5'b11110, cp[20:18]};
      endcase
      send_byte(lead);
      for (i = nbytes - 2; i >= 0 && (nbytes - 1 - i) < keep; i--)
         send_byte({2'b10, cp[6*i +: 6]});
   endtask

   task automatic send_random_char();
      int          pick;
      int          n;
      logic [20:0] cp;
      pick = $urandom_range(0, 99);
      cp   = 21'($urandom_range(0, 21'h1FFFFF));
      n    = $urandom_range(2, 4);
      if (pick < 22) begin
         send_byte(8'($urandom_range(0, 127)));
      end else if (pick < 47) begin
         send_code_point({5'd0, u2kb_pkg::MAP_CP[$urandom_range(0, u2kb_pkg::TblSize - 1)]},
                         2, 2);
      end else if (pick < 57) begin
         send_code_point(cp, 2, 2);
      end else if (pick < 67) begin
         send_code_point(cp, 3, 3);
      end else if (pick < 75) begin
         send_code_point(cp, 4, 4);
      end else if (pick < 85) begin
         send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 93) begin
         send_code_point(cp, n, $urandom_range(1, n - 1));
      end else begin
         // invalid lead in the middle of a sequence, then a stray continuation
         send_code_point(cp, n, $urandom_range(1, n - 1));
         send_byte(8'($urandom_range(8'hF8, 8'hFF)));
         send_byte({2'b10, 6'($urandom_range(0, 63))});
      end
   endtask

   task automatic run_phase(input int send_pct, input int recv_pct, input int upto);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      while (bytes_sent < upto) send_random_char();
   endtask

   initial begin
      track = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 25;
      recv_idle_pct = 60;
      for (int i = 0; i < DirectedLen; i++) send_byte(Directed[i]);
      run_phase(25, 60, 400);
      run_phase(60, 25, 780);
      run_phase(0, 0, 1150);
      req_valid <= 1'b0;
      while (track.outstanding() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      track.close_out();
      if (track.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
